/* hw/rtl/free_list_heap_allocator_defines.svh */
// Assertion macros used by the heap allocator RTL.
`ifndef FREE_LIST_HEAP_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FLHA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FLHA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/flha_pkg.sv */
// Types and codes of the free list heap allocator.
package flha_pkg;

	// Command codes.
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_OVERFLOW   = 2'd1;
	localparam logic [1:0] ST_TABLE_FULL = 2'd2;

	// Fit policy codes.
	localparam logic FIT_FIRST = 1'b0;
	localparam logic FIT_BEST  = 1'b1;

	// One request.
	typedef struct packed {
		logic        cmd;
		logic [31:0] request_size;
		logic [31:0] block_addr;
	} req_t;

	// One result.
	typedef struct packed {
		logic [31:0] payload_addr;
		logic [1:0]  status;
		logic [31:0] segment_bytes;
		logic [31:0] free_bytes;
	} rsp_t;

endpackage

/* hw/rtl/free_list_heap_allocator.sv */
// Top level of the free list heap allocator.
//
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_ready       flha_pkg::req_t in_data
//  out       output     out_valid / out_ready     flha_pkg::rsp_t out_data
//  cfg       input      cfg_we                    cfg_wdata (fit policy)
//
// An item scans the N stored segments through the one read port of the segment RAM,
// then decides, then shifts, which moves no entry unless a segment is removed or
// inserted, when the entries above it move by one index, then finishes.
// A new item is taken in the cycle after the previous result is placed in the
// output register; a stalled output holds only the finishing step.
// Reset clears the control state; the segment RAM needs no clearing pass.
`include "free_list_heap_allocator_defines.svh"

module free_list_heap_allocator #(
	parameter int FREE_ENTRIES = 64,
	parameter int HEADER_BYTES = 24,
	parameter int ADDR_BITS    = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  flha_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output flha_pkg::rsp_t  out_data,
	input  logic            cfg_we,
	input  logic            cfg_wdata
);

	localparam int IW = $clog2(FREE_ENTRIES);
	localparam int CW = $clog2(FREE_ENTRIES + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(FREE_ENTRIES);
	localparam logic [31:0] LIMIT = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
		32'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [33:0] LIMIT_P1 = {2'b00, LIMIT} + 34'd1;
	localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
	localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);
	localparam logic [33:0] HDR34 = 34'(HEADER_BYTES);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_APPLY = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t state_q;

	// Architectural state.
	logic [CW-1:0] count_q;
	logic [31:0]   top_q;
	logic [31:0]   total_q;
	logic          policy_q;

	// Current item.
	logic          cmd_q;
	logic [31:0]   n_q;
	logic [31:0]   p_q;
	logic [32:0]   need_q;

	// Scan pipeline.
	logic [CW-1:0] ri_q;
	logic          rv_s1;
	logic [CW-1:0] rix_s1;

	// Allocation trackers: first hit and best larger segment.
	logic          fh_q, fx_q, bh_q;
	logic [CW-1:0] fidx_q, bidx_q;
	logic [31:0]   fstart_q, flen_q, bstart_q, blen_q;

	// Free trackers: left and right neighbors.
	logic          found_q;
	logic [CW-1:0] pos_q;
	logic [31:0]   lstart_q, llen_q, rstart_q, rlen_q;

	// Shift engine and pending write.
	logic          sh_up_q;
	logic [CW-1:0] sh_n_q;
	logic [CW-1:0] sh_ri_q;
	logic          sv_s1;
	logic [IW-1:0] swi_s1;
	logic          pw_q;
	logic [IW-1:0] pw_idx_q;
	logic [63:0]   pw_data_q;

	// Result.
	logic [31:0]   res_addr_q;
	logic [1:0]    res_status_q;
	logic          out_valid_q;
	flha_pkg::rsp_t out_q;

	// Memory ports.
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [63:0]   mem_wdata;
	logic [IW-1:0] mem_raddr;
	logic [63:0]   mem_rdata;

	flha_ram #(
		.WIDTH(64),
		.DEPTH(FREE_ENTRIES)
	) u_seg_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	logic        in_xfer;
	logic        out_free;
	logic        scan_issue;
	logic        shift_issue;
	logic [31:0] e_start, e_len;
	logic        e_gt, e_eq;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign scan_issue  = (state_q == S_SCAN) && (ri_q < count_q);
	assign shift_issue = (state_q == S_SHIFT) && (sh_n_q != '0);
	assign e_start = mem_rdata[63:32];
	assign e_len   = mem_rdata[31:0];
	assign e_gt    = {1'b0, e_len} > need_q;
	assign e_eq    = e_len == n_q;

	// Memory port selection.
	always_comb begin
		mem_raddr = shift_issue ? sh_ri_q[IW-1:0] : ri_q[IW-1:0];
		mem_we    = 1'b0;
		mem_waddr = swi_s1;
		mem_wdata = mem_rdata;
		if (state_q == S_SHIFT && sv_s1) begin
			mem_we = 1'b1;
		end else if (state_q == S_DONE && pw_q) begin
			mem_we    = 1'b1;
			mem_waddr = pw_idx_q;
			mem_wdata = pw_data_q;
		end
	end

	// Decision terms for the apply step.
	logic          sel_f, sel_b, a_found, a_exact;
	logic [CW-1:0] a_idx;
	logic [31:0]   a_start, a_len;
	logic [33:0]   top_end;
	logic          f_left, f_right;
	logic [32:0]   a_sub;
	logic [33:0]   add_sum;
	logic          ap_pw, ap_up;
	logic [1:0]    ap_status;
	logic [31:0]   ap_addr;
	logic [CW-1:0] ap_n, ap_ri;
	logic [IW-1:0] ap_idx;
	logic [63:0]   ap_data;

	always_comb begin
		sel_f   = fh_q;
		sel_b   = !fh_q && bh_q && (policy_q == flha_pkg::FIT_BEST);
		a_found = sel_f || sel_b;
		a_exact = sel_f && fx_q;
		a_idx   = sel_f ? fidx_q : bidx_q;
		a_start = sel_f ? fstart_q : bstart_q;
		a_len   = sel_f ? flen_q : blen_q;
		top_end = {2'b00, top_q} + {1'b0, need_q};
		f_left  = (pos_q != '0) &&
			({2'b00, lstart_q} + {2'b00, llen_q} + HDR34 == {2'b00, p_q});
		f_right = found_q && ({1'b0, p_q} + need_q == {1'b0, rstart_q});
		a_sub   = a_exact ? ({1'b0, a_len} + HDR33) : need_q;
		add_sum = {2'b00, total_q} + {1'b0, need_q};

		// Result, pending write and shift range of the current item.
		ap_addr   = '0;
		ap_status = flha_pkg::ST_OK;
		ap_pw     = 1'b0;
		ap_up     = 1'b0;
		ap_n      = '0;
		ap_ri     = '0;
		ap_idx    = pos_q[IW-1:0];
		ap_data   = {p_q, n_q};
		if (cmd_q == flha_pkg::CMD_ALLOC) begin
			ap_idx  = a_idx[IW-1:0];
			ap_data = {a_start + need_q[31:0], a_len - need_q[31:0]};
			if (a_found) begin
				ap_addr = a_start + HDR32;
				if (a_exact) begin
					ap_n  = count_q - a_idx - 1'b1;
					ap_ri = a_idx + 1'b1;
				end else begin
					ap_pw = 1'b1;
				end
			end else if (top_end <= LIMIT_P1) begin
				ap_addr = top_q + HDR32;
			end else begin
				ap_status = flha_pkg::ST_OVERFLOW;
			end
		end else begin
			priority if (f_left && f_right) begin
				ap_pw   = 1'b1;
				ap_idx  = IW'(pos_q - 1'b1);
				ap_data = {lstart_q, llen_q + need_q[31:0] + rlen_q + HDR32};
				ap_n    = count_q - pos_q - 1'b1;
				ap_ri   = pos_q + 1'b1;
			end else if (f_left) begin
				ap_pw   = 1'b1;
				ap_idx  = IW'(pos_q - 1'b1);
				ap_data = {lstart_q, llen_q + need_q[31:0]};
			end else if (f_right) begin
				ap_pw   = 1'b1;
				ap_data = {p_q, rlen_q + need_q[31:0]};
			end else if (count_q == FULL_COUNT) begin
				ap_status = flha_pkg::ST_TABLE_FULL;
			end else begin
				ap_pw = 1'b1;
				ap_up = 1'b1;
				ap_n  = count_q - pos_q;
				ap_ri = count_q - 1'b1;
			end
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			top_q       <= '0;
			total_q     <= '0;
			policy_q    <= flha_pkg::FIT_FIRST;
			rv_s1       <= 1'b0;
			sv_s1       <= 1'b0;
			pw_q        <= 1'b0;
			out_valid_q <= 1'b0;
			fh_q        <= 1'b0;
			bh_q        <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= cfg_wdata;
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						rv_s1   <= 1'b0;
						fh_q    <= 1'b0;
						bh_q    <= 1'b0;
						found_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					rv_s1 <= scan_issue;
					if (rv_s1) begin
						if (cmd_q == flha_pkg::CMD_ALLOC) begin
							if (!fh_q && (policy_q == flha_pkg::FIT_BEST ? e_eq :
								(e_gt || e_eq))) begin
								fh_q <= 1'b1;
							end
							if (e_gt) begin
								bh_q <= 1'b1;
							end
						end else if (!found_q && !(e_start < p_q)) begin
							found_q <= 1'b1;
						end
					end
					if (!rv_s1 && !scan_issue) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					pw_q    <= ap_pw;
					sv_s1   <= 1'b0;
					state_q <= S_SHIFT;
					if (cmd_q == flha_pkg::CMD_ALLOC) begin
						if (a_found) begin
							total_q <= ({1'b0, total_q} < a_sub) ? '0 :
								32'({1'b0, total_q} - a_sub);
							if (a_exact) begin
								count_q <= count_q - 1'b1;
							end
						end else if (top_end <= LIMIT_P1) begin
							top_q <= top_end[31:0];
						end
					end else if (ap_status != flha_pkg::ST_TABLE_FULL) begin
						total_q <= (add_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF :
							add_sum[31:0];
						if (f_left && f_right) begin
							count_q <= count_q - 1'b1;
						end else if (!f_left && !f_right) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				S_SHIFT: begin
					sv_s1 <= shift_issue;
					if (!sv_s1 && !shift_issue) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						pw_q    <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					cmd_q  <= in_data.cmd;
					n_q    <= in_data.request_size;
					p_q    <= (in_data.block_addr - HDR32) & LIMIT;
					need_q <= {1'b0, in_data.request_size} + HDR33;
					ri_q   <= '0;
					pos_q  <= '0;
				end
			end
			S_SCAN: begin
				// Issue the next read and evaluate the entry read last cycle.
				if (scan_issue) begin
					ri_q <= ri_q + 1'b1;
				end
				rix_s1 <= ri_q;
				if (rv_s1) begin
					if (cmd_q == flha_pkg::CMD_ALLOC) begin
						if (!fh_q && (policy_q == flha_pkg::FIT_BEST ? e_eq :
							(e_gt || e_eq))) begin
							fx_q     <= !e_gt;
							fidx_q   <= rix_s1;
							fstart_q <= e_start;
							flen_q   <= e_len;
						end
						if (e_gt && (!bh_q || blen_q > e_len)) begin
							bidx_q   <= rix_s1;
							bstart_q <= e_start;
							blen_q   <= e_len;
						end
					end else if (!found_q) begin
						if (e_start < p_q) begin
							lstart_q <= e_start;
							llen_q   <= e_len;
							pos_q    <= rix_s1 + 1'b1;
						end else begin
							rstart_q <= e_start;
							rlen_q   <= e_len;
							pos_q    <= rix_s1;
						end
					end
				end
			end
			S_APPLY: begin
				// Decide the result, the pending write and the shift range.
				res_addr_q   <= ap_addr;
				res_status_q <= ap_status;
				sh_up_q      <= ap_up;
				sh_n_q       <= ap_n;
				sh_ri_q      <= ap_ri;
				pw_idx_q     <= ap_idx;
				pw_data_q    <= ap_data;
			end
			S_SHIFT: begin
				// Move one entry per cycle, toward higher or lower indexes.
				if (shift_issue) begin
					sh_n_q <= sh_n_q - 1'b1;
					if (sh_up_q) begin
						swi_s1  <= IW'(sh_ri_q + 1'b1);
						sh_ri_q <= sh_ri_q - 1'b1;
					end else begin
						swi_s1  <= IW'(sh_ri_q - 1'b1);
						sh_ri_q <= sh_ri_q + 1'b1;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_q.payload_addr  <= res_addr_q;
					out_q.status        <= res_status_q;
					out_q.segment_bytes <= top_q;
					out_q.free_bytes    <= total_q;
				end
			end
			default: begin
				ri_q <= ri_q;
			end
		endcase
	end

	// Checks on the sequencing of the table.
	`FLHA_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= FULL_COUNT,
		"segment count beyond table size")
	`FLHA_ASSERT_IMPL(a_full_status, clk, arst_n,
		state_q == S_DONE && res_status_q == flha_pkg::ST_TABLE_FULL,
		count_q == FULL_COUNT, "table full reported with free entries")
	`FLHA_ASSERT_IMPL(a_shift_hazard, clk, arst_n, shift_issue && sv_s1,
		mem_waddr != mem_raddr, "shift writes the entry it reads")
	`FLHA_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_xfer, !in_ready,
		"second transfer taken while busy")

endmodule

/* hw/rtl/flha_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
module flha_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* dv/free_list_heap_allocator_tb.sv */
// Self-checking testbench for the free list heap allocator with a built-in allocator model.

module free_list_heap_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FREE_ENTRIES = 64;
	localparam int HDR = 24;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 200;

	// Allocator state as seen from outside: free table, heap top, free byte count.
	typedef struct {
		bit [31:0]   start[FREE_ENTRIES];
		bit [31:0]   len[FREE_ENTRIES];
		int unsigned count;
		bit [31:0]   top;
		bit [31:0]   total;
		bit          policy;
	} heap_t;

	// Kinds of entries in the stimulus queue.
	typedef enum int {K_ITEM, K_CFG, K_DRAIN, K_MODE, K_HOLD} step_kind_t;

	typedef struct {
		step_kind_t     kind;
		flha_pkg::req_t req;
		bit             policy;
		int             idle_pct;
		int             stall_pct;
	} step_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	flha_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	flha_pkg::rsp_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;

	heap_t   model_heap;
	heap_t   plan_heap;
	step_t   pending_q[$];
	flha_pkg::rsp_t expected_q[$];
	bit [31:0] live_addr[$];
	bit [31:0] live_size[$];

	int   errors = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;
	int   quiet_cycles = 0;
	int   hold_left = 0;
	logic hold_go = 1'b0;
	int   cycles = 0;
	int   n_alloc = 0;
	int   n_free = 0;
	int   n_overflow = 0;
	int   n_full = 0;
	int   n_checked = 0;

	free_list_heap_allocator #(
		.FREE_ENTRIES(FREE_ENTRIES),
		.HEADER_BYTES(HDR),
		.ADDR_BITS(32)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Clock: 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Removes one free segment and closes the gap.
	function automatic void drop_segment(ref heap_t h, input int idx);
		for (int k = idx; k + 1 < h.count; k++) begin
			h.start[k] = h.start[k + 1];
			h.len[k] = h.len[k + 1];
		end
		h.count--;
	endfunction

	// Lowers the free byte count, saturating at zero.
	function automatic void shrink_free_total(ref heap_t h, input bit [63:0] v);
		h.total = (v > 64'(h.total)) ? 32'd0 : h.total - v[31:0];
	endfunction

	// Applies one request to the allocator state and returns the result it gives.
	function automatic flha_pkg::rsp_t heap_step(ref heap_t h, input flha_pkg::req_t r);
		flha_pkg::rsp_t o;
		bit [63:0] need;
		bit [63:0] blk;
		bit [63:0] p;
		bit [63:0] sum;
		int        pick;
		int        pos;
		bit        found;
		bit        exact;
		bit        left;
		bit        right;
		o = '0;
		found = 1'b0;
		exact = 1'b0;
		pick = 0;
		if (r.cmd == flha_pkg::CMD_ALLOC) begin
			need = 64'(r.request_size) + 64'(HDR);
			// Address-order scan: first fit takes split or exact, best fit only exact here.
			for (int i = 0; i < h.count && !found; i++) begin
				if (h.policy == flha_pkg::FIT_FIRST && 64'(h.len[i]) > need) begin
					pick = i;
					found = 1'b1;
				end else if (h.len[i] == r.request_size) begin
					pick = i;
					found = 1'b1;
					exact = 1'b1;
				end
			end
			// Best fit without an exact match: smallest splittable segment, lowest address on ties.
			if (!found && h.policy == flha_pkg::FIT_BEST) begin
				for (int i = 0; i < h.count; i++) begin
					if (64'(h.len[i]) > need && (!found || h.len[pick] > h.len[i])) begin
						pick = i;
						found = 1'b1;
					end
				end
			end
			if (found) begin
				o.payload_addr = h.start[pick] + 32'(HDR);
				if (exact) begin
					shrink_free_total(h, 64'(h.len[pick]) + 64'(HDR));
					drop_segment(h, pick);
				end else begin
					h.start[pick] = h.start[pick] + need[31:0];
					h.len[pick] = h.len[pick] - need[31:0];
					shrink_free_total(h, need);
				end
			end else if (64'(h.top) + need > 64'h1_0000_0000) begin
				o.status = flha_pkg::ST_OVERFLOW;
			end else begin
				o.payload_addr = h.top + 32'(HDR);
				h.top = h.top + need[31:0];
			end
		end else begin
			p = 64'(r.block_addr - 32'(HDR));
			blk = 64'(r.request_size) + 64'(HDR);
			pos = 0;
			while (pos < h.count && 64'(h.start[pos]) < p)
				pos++;
			left = pos > 0 && 64'(h.start[pos - 1]) + 64'(h.len[pos - 1]) + 64'(HDR) == p;
			right = pos < h.count && p + blk == 64'(h.start[pos]);
			// Coalesce with whichever neighbors touch the freed block.
			if (left && right) begin
				h.len[pos - 1] = h.len[pos - 1] + blk[31:0] + h.len[pos] + 32'(HDR);
				drop_segment(h, pos);
			end else if (left) begin
				h.len[pos - 1] = h.len[pos - 1] + blk[31:0];
			end else if (right) begin
				h.start[pos] = p[31:0];
				h.len[pos] = h.len[pos] + blk[31:0];
			end else if (h.count >= FREE_ENTRIES) begin
				o.status = flha_pkg::ST_TABLE_FULL;
			end else begin
				for (int k = h.count; k > pos; k--) begin
					h.start[k] = h.start[k - 1];
					h.len[k] = h.len[k - 1];
				end
				h.start[pos] = p[31:0];
				h.len[pos] = r.request_size;
				h.count++;
			end
			if (o.status == flha_pkg::ST_OK) begin
				sum = 64'(h.total) + blk;
				h.total = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
			end
		end
		o.segment_bytes = h.top;
		o.free_bytes = h.total;
		return o;
	endfunction

	// Queues one request; the planning copy of the state tracks which blocks are live.
	task automatic plan_request(input logic cmd, input bit [31:0] size, input bit [31:0] addr);
		step_t s;
		flha_pkg::rsp_t o;
		s = '{kind: K_ITEM, req: '0, policy: 1'b0, idle_pct: 0, stall_pct: 0};
		s.req.cmd = cmd;
		s.req.request_size = size;
		s.req.block_addr = addr;
		o = heap_step(plan_heap, s.req);
		if (cmd == flha_pkg::CMD_ALLOC && o.status == flha_pkg::ST_OK) begin
			live_addr.push_back(o.payload_addr);
			live_size.push_back(size);
		end
		pending_q.push_back(s);
	endtask

	// Frees one live block, chosen by position in the live list.
	task automatic plan_free_live(input int idx);
		bit [31:0] a;
		bit [31:0] n;
		a = live_addr[idx];
		n = live_size[idx];
		live_addr.delete(idx);
		live_size.delete(idx);
		plan_request(flha_pkg::CMD_FREE, n, a);
	endtask

	// Queues a control step: wait for idle, policy write, idle and stall mode or receiver hold-off.
	task automatic plan_control(input step_kind_t kind, input bit pol, input int ip, input int sp);
		step_t s;
		s = '{kind: kind, req: '0, policy: pol, idle_pct: ip, stall_pct: sp};
		if (kind == K_CFG)
			plan_heap.policy = pol;
		pending_q.push_back(s);
	endtask

	// A mostly well-formed mix of allocations and frees, with some noise.
	task automatic plan_random_mix(input int count);
		int pick;
		bit [31:0] sz;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			case ($urandom_range(5))
				0: sz = 32'd0;
				1: sz = 32'd8;
				2: sz = 32'd16;
				3: sz = 32'd40;
				default: sz = $urandom_range(200);
			endcase
			if (pick < 45 || (pick < 85 && live_addr.size() == 0)) begin
				plan_request(flha_pkg::CMD_ALLOC, sz, $urandom);
			end else if (pick < 85) begin
				plan_free_live($urandom_range(live_addr.size() - 1));
			end else if (pick < 93) begin
				plan_request(flha_pkg::CMD_FREE, $urandom, $urandom);
			end else begin
				plan_request(flha_pkg::CMD_ALLOC, $urandom, $urandom);
			end
		end
	endtask

	// Reset, stimulus plan, end of run.
	initial begin
		int burst_first;
		plan_heap = '{default: '0};
		model_heap = '{default: '0};

		// Directed: exact and split fits, both-side coalescing, wrap below header, overflow.
		plan_request(flha_pkg::CMD_ALLOC, 32'd0, 32'hFFFF_FFFF);
		plan_request(flha_pkg::CMD_ALLOC, 32'd1, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd40, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd16, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd8, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'hFFFF_FFE8, 32'd0);
		plan_free_live(2);
		plan_free_live(0);
		plan_free_live(0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd16, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd1, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd0, 32'd0);
		plan_request(flha_pkg::CMD_FREE, 32'd5, 32'd0);
		plan_request(flha_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		plan_control(K_DRAIN, 1'b0, 0, 0);
		plan_control(K_CFG, flha_pkg::FIT_BEST, 0, 0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd8, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd100, 32'd0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd5, 32'd0);
		plan_free_live(0);

		// Random phases with different idle and stall patterns and policies.
		plan_control(K_DRAIN, 1'b0, 0, 0);
		plan_control(K_CFG, flha_pkg::FIT_FIRST, 0, 0);
		plan_control(K_MODE, 1'b0, 0, 0);
		plan_random_mix(70);
		plan_control(K_DRAIN, 1'b0, 0, 0);
		plan_control(K_CFG, flha_pkg::FIT_BEST, 0, 0);
		plan_control(K_MODE, 1'b0, 68, 0);
		plan_random_mix(70);
		plan_control(K_DRAIN, 1'b0, 0, 0);
		plan_control(K_CFG, flha_pkg::FIT_FIRST, 0, 0);
		plan_control(K_MODE, 1'b0, 0, 68);
		plan_random_mix(70);

		// Fragment the table until it overflows, under a long receiver hold-off.
		plan_control(K_DRAIN, 1'b0, 0, 0);
		plan_control(K_MODE, 1'b0, 23, 23);
		plan_control(K_HOLD, 1'b0, 0, 0);
		burst_first = live_addr.size();
		for (int i = 0; i < 100; i++)
			plan_request(flha_pkg::CMD_ALLOC, 32'd8, $urandom);
		for (int i = 0; i < 50 && burst_first + i < live_addr.size(); i++)
			plan_free_live(burst_first + i);
		plan_control(K_DRAIN, 1'b0, 0, 0);
		plan_control(K_CFG, flha_pkg::FIT_BEST, 0, 0);
		while (live_addr.size() > burst_first)
			plan_free_live(live_addr.size() - 1);
		plan_random_mix(70);

		// Take the rest of the address range from the top, then overflow and free it.
		plan_control(K_DRAIN, 1'b0, 0, 0);
		plan_control(K_MODE, 1'b0, 0, 0);
		if (64'(plan_heap.top) + 64'(HDR) <= 64'h1_0000_0000)
			plan_request(flha_pkg::CMD_ALLOC,
				32'(64'h1_0000_0000 - 64'(plan_heap.top) - 64'(HDR)), 0);
		plan_request(flha_pkg::CMD_ALLOC, 32'd0, 32'd0);
		if (live_addr.size() > 0)
			plan_free_live(live_addr.size() - 1);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_q.size() != 0)
			report_mismatch("results still outstanding", expected_q.size(), 0);
		$display("Run covered %0d allocations and %0d frees under both fit policies;", n_alloc,
			n_free);
		$display("%0d results checked, %0d heap overflows, %0d table-full drops.", n_checked,
			n_overflow, n_full);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Prints one mismatch line and counts it.
	task automatic report_mismatch(input string what, input bit [31:0] got,
		input bit [31:0] want);
		$display("MISMATCH at cycle %0d: %s: got 0x%08h, expected 0x%08h", cycles, what,
			got, want);
		errors++;
	endtask

	// Driver: predicts each accepted request and offers the next queued step.
	always @(posedge clk or negedge arst_n) begin : driver
		logic next_valid;
		logic next_we;
		logic next_hold;
		step_t s;
		flha_pkg::rsp_t o;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			cfg_we <= 1'b0;
			cfg_wdata <= 1'b0;
			hold_go <= 1'b0;
		end else begin
			next_valid = in_valid;
			next_we = 1'b0;
			next_hold = 1'b0;
			if (in_valid && in_ready) begin
				o = heap_step(model_heap, in_data);
				expected_q.push_back(o);
				next_valid = 1'b0;
				if (in_data.cmd == flha_pkg::CMD_ALLOC)
					n_alloc++;
				else
					n_free++;
				if (o.status == flha_pkg::ST_OVERFLOW)
					n_overflow++;
				if (o.status == flha_pkg::ST_TABLE_FULL)
					n_full++;
			end
			quiet_cycles = (expected_q.size() == 0 && !next_valid) ? quiet_cycles + 1 : 0;
			if (!next_valid && pending_q.size() != 0) begin
				s = pending_q[0];
				case (s.kind)
					K_ITEM: begin
						if ($urandom_range(99) >= idle_pct) begin
							next_valid = 1'b1;
							in_data <= s.req;
							void'(pending_q.pop_front());
						end
					end
					K_CFG: begin
						if (quiet_cycles >= 8) begin
							next_we = 1'b1;
							cfg_wdata <= s.policy;
							model_heap.policy = s.policy;
							void'(pending_q.pop_front());
						end
					end
					K_DRAIN: begin
						if (quiet_cycles >= 8)
							void'(pending_q.pop_front());
					end
					K_MODE: begin
						idle_pct = s.idle_pct;
						stall_pct = s.stall_pct;
						void'(pending_q.pop_front());
					end
					default: begin
						next_hold = 1'b1;
						void'(pending_q.pop_front());
					end
				endcase
			end
			in_valid <= next_valid;
			cfg_we <= next_we;
			hold_go <= next_hold;
		end
	end

	// Receiver hold-off counter.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Monitor: checks each result transfer against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin : monitor
		flha_pkg::rsp_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing pending", out_data.payload_addr, 0);
				end else begin
					want = expected_q.pop_front();
					n_checked++;
					if (out_data.payload_addr !== want.payload_addr)
						report_mismatch("payload_addr", out_data.payload_addr, want.payload_addr);
					if (out_data.status !== want.status)
						report_mismatch("status", 32'(out_data.status), 32'(want.status));
					if (out_data.segment_bytes !== want.segment_bytes)
						report_mismatch("segment_bytes", out_data.segment_bytes,
							want.segment_bytes);
					if (out_data.free_bytes !== want.free_bytes)
						report_mismatch("free_bytes", out_data.free_bytes, want.free_bytes);
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles.", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

endmodule
